/* hdl/pts_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// pts_pkg
// Shared types, codes and helpers of the periodic task slot scheduler.
// ----------------------------------------------------------------------------
package pts_pkg;

   localparam int SLOTS       = 8;
   localparam int CATCHUP_MAX = 8;
   localparam int SLOT_W      = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int CNT_W       = $clog2(CATCHUP_MAX + 1);
   localparam int CSR_ADDR_W  = 3;

   localparam logic [31:0] PERIOD_LIMIT = 32'h8000_0000;
   localparam logic [31:0] TICK_NONE    = 32'hFFFF_FFFF;

   // opcodes
   localparam logic [1:0] OP_START   = 2'd0;
   localparam logic [1:0] OP_STOP    = 2'd1;
   localparam logic [1:0] OP_PROCESS = 2'd2;
   localparam logic [1:0] OP_QUERY   = 2'd3;

   // result status codes
   localparam logic [1:0] RS_OK       = 2'd0;
   localparam logic [1:0] RS_PARAM    = 2'd1;
   localparam logic [1:0] RS_FULL     = 2'd2;
   localparam logic [1:0] RS_NOTFOUND = 2'd3;

   // register indexes
   localparam logic REG_TABLE = 1'b0;
   localparam logic REG_COUNT = 1'b1;

   typedef struct packed {
      logic [1:0]  opcode;
      logic [15:0] task_id;
      logic [31:0] period;
      logic        handler_present;
      logic [31:0] now;
   } req_type;

   typedef struct packed {
      logic [1:0]  status;
      logic        fired;
      logic [15:0] fired_id;
      logic [31:0] next_due;
      logic        last;
   } rsp_type;

   typedef struct packed {
      logic       load;
      logic       scan;
      logic       step;
      logic       clear_cur;
      logic       catch_clr;
      logic       catch_add;
      logic       rebase;
      logic       commit;
      logic       emit;
      logic       emit_fired;
      logic       emit_last;
      logic [1:0] emit_status;
   } cmd_type;

   typedef struct packed {
      logic [1:0] op;
      logic       start_bad;
      logic       present;
      logic       idx_last;
      logic       due_now;
      logic       stale;
      logic       cu_late;
      logic       cu_max;
      logic       dup;
      logic       free_found;
      logic       found;
   } sts_type;

   // wrap-safe: now has reached due
   function automatic logic is_late(input logic [31:0] now, input logic [31:0] due);
      logic [31:0] d;
      d = now - due;
      return ~d[31];
   endfunction

   // wrap-safe: a lies strictly before b
   function automatic logic is_before(input logic [31:0] a, input logic [31:0] b);
      logic [31:0] d;
      d = a - b;
      return d[31];
   endfunction

endpackage
`default_nettype wire

/* hdl/pts_dpath.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// pts_dpath
// Slot table, request latch, scan index, catch-up counter and result former.
// ----------------------------------------------------------------------------
module pts_dpath (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire pts_pkg::req_type  req_data,
   input  wire logic              cfg_clear,
   input  wire logic              table_present,
   input  wire logic [15:0]       task_count,
   input  wire pts_pkg::cmd_type  cmd,
   output      pts_pkg::sts_type  sts,
   output      pts_pkg::rsp_type  rsp_out
);
   import pts_pkg::*;

   req_type           req_ff;
   logic [SLOT_W-1:0] idx_ff, idx_in;
   logic [SLOT_W-1:0] free_idx_ff;
   logic              dup_ff, free_found_ff, found_ff;
   logic [31:0]       best_ff;
   logic [CNT_W-1:0]  n_ff, n_in;
   logic [SLOTS-1:0]  active_ff;
   logic [15:0]       task_ff   [SLOTS];
   logic [31:0]       period_ff [SLOTS];
   logic [31:0]       due_ff    [SLOTS];

   logic        cur_active;
   logic [15:0] cur_task;
   logic [31:0] cur_period, cur_due;
   logic [15:0] eff_count;
   logic        hit, stale, cur_late, start_bad;

   always_comb begin
      cur_active = active_ff[idx_ff];
      cur_task   = task_ff[idx_ff];
      cur_period = period_ff[idx_ff];
      cur_due    = due_ff[idx_ff];
      eff_count  = table_present ? task_count : 16'd0;
      hit        = cur_active && (cur_task == req_ff.task_id);
      stale      = cur_task >= eff_count;
      cur_late   = is_late(req_ff.now, cur_due);
      start_bad  = !table_present || (req_ff.task_id >= eff_count) ||
                   !req_ff.handler_present || (req_ff.period == 32'd0) ||
                   (req_ff.period >= PERIOD_LIMIT);
      idx_in     = cmd.step ? idx_ff + SLOT_W'(1) : idx_ff;
      n_in       = cmd.catch_clr ? '0 : (cmd.catch_add ? n_ff + CNT_W'(1) : n_ff);
   end

   always_comb begin
      sts.op         = req_ff.opcode;
      sts.start_bad  = start_bad;
      sts.present    = table_present;
      sts.idx_last   = idx_ff == SLOT_W'(SLOTS - 1);
      sts.due_now    = cur_active && cur_late;
      sts.stale      = stale;
      sts.cu_late    = cur_late;
      sts.cu_max     = n_ff == CNT_W'(CATCHUP_MAX);
      sts.dup        = dup_ff;
      sts.free_found = free_found_ff;
      sts.found      = found_ff;
   end

   always_comb begin
      rsp_out.status   = cmd.emit_status;
      rsp_out.fired    = cmd.emit_fired;
      rsp_out.fired_id = cmd.emit_fired ? cur_task : 16'd0;
      rsp_out.next_due = (req_ff.opcode == OP_QUERY) ?
                         (found_ff ? best_ff : TICK_NONE) : 32'd0;
      rsp_out.last     = cmd.emit_last;
   end

   // request latch and scan bookkeeping
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         req_ff <= req_data;
      end
      if (cmd.scan && (req_ff.opcode == OP_QUERY) && cur_active && !stale &&
          (!found_ff || is_before(cur_due, best_ff))) begin
         best_ff <= cur_due;
      end
      if (cmd.scan && (req_ff.opcode == OP_START) && !cur_active && !free_found_ff) begin
         free_idx_ff <= idx_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff        <= '0;
         n_ff          <= '0;
         dup_ff        <= 1'b0;
         free_found_ff <= 1'b0;
         found_ff      <= 1'b0;
      end else if (cmd.load) begin
         idx_ff        <= '0;
         n_ff          <= '0;
         dup_ff        <= 1'b0;
         free_found_ff <= 1'b0;
         found_ff      <= 1'b0;
      end else begin
         idx_ff <= idx_in;
         n_ff   <= n_in;
         if (cmd.scan) begin
            unique case (req_ff.opcode)
               OP_START: begin
                  if (hit) dup_ff <= 1'b1;
                  if (!cur_active) free_found_ff <= 1'b1;
               end
               OP_STOP: begin
                  if (hit) found_ff <= 1'b1;
               end
               OP_QUERY: begin
                  if (cur_active && !stale) found_ff <= 1'b1;
               end
               default: begin
               end
            endcase
         end
      end
   end

   // active marks
   always_ff @(posedge clock) begin
      if (reset || cfg_clear) begin
         active_ff <= '0;
      end else begin
         if (cmd.scan && (req_ff.opcode == OP_STOP) && hit) active_ff[idx_ff] <= 1'b0;
         if (cmd.clear_cur) active_ff[idx_ff] <= 1'b0;
         if (cmd.commit) active_ff[free_idx_ff] <= 1'b1;
      end
   end

   // slot payload
   always_ff @(posedge clock) begin
      if (cmd.commit) begin
         task_ff[free_idx_ff]   <= req_ff.task_id;
         period_ff[free_idx_ff] <= req_ff.period;
         due_ff[free_idx_ff]    <= req_ff.now + req_ff.period;
      end else if (cmd.catch_add) begin
         due_ff[idx_ff] <= cur_due + cur_period;
      end else if (cmd.rebase) begin
         due_ff[idx_ff] <= req_ff.now + cur_period;
      end
   end

   a_catch_bound: assert property (@(posedge clock) disable iff (reset)
      n_ff <= CNT_W'(CATCHUP_MAX))
      else $error("catch-up count above limit");

   a_commit_free: assert property (@(posedge clock) disable iff (reset)
      cmd.commit |-> (free_found_ff && !dup_ff && !active_ff[free_idx_ff]))
      else $error("start written into an occupied slot");

endmodule
`default_nettype wire

/* hdl/pts_ctrl.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// pts_ctrl
// Sequencer of the slot scans, catch-up steps and result beats.
// ----------------------------------------------------------------------------
module pts_ctrl (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output      logic             req_stall,
   input  wire logic             out_free,
   input  wire pts_pkg::sts_type sts,
   output      pts_pkg::cmd_type cmd
);
   import pts_pkg::*;

   localparam logic [2:0] S_IDLE     = 3'd0;
   localparam logic [2:0] S_DISPATCH = 3'd1;
   localparam logic [2:0] S_SCAN     = 3'd2;
   localparam logic [2:0] S_PSCAN    = 3'd3;
   localparam logic [2:0] S_CATCH    = 3'd4;
   localparam logic [2:0] S_CHECK    = 3'd5;
   localparam logic [2:0] S_FIRE     = 3'd6;
   localparam logic [2:0] S_FINISH   = 3'd7;

   logic [2:0] state_ff, state_in;
   logic [1:0] final_status;

   always_comb begin
      unique case (sts.op)
         OP_START: begin
            if (sts.start_bad) final_status = RS_PARAM;
            else if (sts.dup || sts.free_found) final_status = RS_OK;
            else final_status = RS_FULL;
         end
         OP_STOP: final_status = sts.found ? RS_OK : RS_NOTFOUND;
         default: final_status = RS_OK;
      endcase
   end

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = S_DISPATCH;
            end
         end
         S_DISPATCH: begin
            priority if (sts.op == OP_START && sts.start_bad) state_in = S_FINISH;
            else if (sts.op == OP_PROCESS && !sts.present) state_in = S_FINISH;
            else if (sts.op == OP_PROCESS) state_in = S_PSCAN;
            else state_in = S_SCAN;
         end
         S_SCAN: begin
            cmd.scan = 1'b1;
            if (sts.idx_last) state_in = S_FINISH;
            else cmd.step = 1'b1;
         end
         S_PSCAN: begin
            if (sts.due_now && !sts.stale) begin
               cmd.catch_clr = 1'b1;
               state_in      = S_CATCH;
            end else begin
               cmd.clear_cur = sts.due_now;
               if (sts.idx_last) state_in = S_FINISH;
               else cmd.step = 1'b1;
            end
         end
         S_CATCH: begin
            cmd.catch_add = 1'b1;
            state_in      = S_CHECK;
         end
         S_CHECK: begin
            if (sts.cu_late && !sts.cu_max) begin
               state_in = S_CATCH;
            end else begin
               cmd.rebase = sts.cu_late;
               state_in   = S_FIRE;
            end
         end
         S_FIRE: begin
            if (out_free) begin
               cmd.emit        = 1'b1;
               cmd.emit_fired  = 1'b1;
               cmd.emit_status = RS_OK;
               if (sts.idx_last) begin
                  state_in = S_FINISH;
               end else begin
                  cmd.step = 1'b1;
                  state_in = S_PSCAN;
               end
            end
         end
         S_FINISH: begin
            if (out_free) begin
               cmd.emit        = 1'b1;
               cmd.emit_last   = 1'b1;
               cmd.emit_status = final_status;
               cmd.commit      = (sts.op == OP_START) && !sts.start_bad &&
                                 !sts.dup && sts.free_found;
               state_in        = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_stall = state_ff != S_IDLE;

   a_emit_free: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |-> out_free)
      else $error("result beat issued into a full output register");

   a_last_idle: assert property (@(posedge clock) disable iff (reset)
      (cmd.emit && cmd.emit_last) |=> (state_ff == S_IDLE))
      else $error("closing beat did not return to idle");

   a_catch_entry: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_CATCH) |-> ($past(state_ff) == S_PSCAN || $past(state_ff) == S_CHECK))
      else $error("catch-up step entered from a wrong state");

endmodule
`default_nettype wire

/* hdl/periodic_task_slot_scheduler_core.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// periodic_task_slot_scheduler_core
// Slot table of periodic tasks with start, stop, process and next-due query.
// ----------------------------------------------------------------------------
// Usage:
//  - req channel (req_valid/req_stall/req_data) takes one operation per beat;
//    it is taken only while the sequencer is idle, one operation at a time.
//  - rsp channel gives the result beats; last marks the final beat of an
//    operation. Process gives one fired beat per due, non-stale slot, then a closing beat.
//  - start, stop, query: accept, dispatch, a scan of one slot per cycle, then
//    the final beat; a rejected start skips the scan.
//  - process: accept, dispatch and a scan of all slots; each fired slot takes
//    k (1 to CATCHUP_MAX) period steps, each one catch step and one check step,
//    before its beat. Without a table it skips the scan.
//  - results sit in an output register; a stalled receiver holds the sequencer
//    at its next beat until the register drains.
//  - reset clears all slots and both registers; a register write over the
//    APB port also clears all slots. Write only while idle.
// ----------------------------------------------------------------------------
module periodic_task_slot_scheduler_core (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_valid,
   output      logic                              req_stall,
   input  wire pts_pkg::req_type                  req_data,
   output      logic                              rsp_valid,
   input  wire logic                              rsp_stall,
   output      pts_pkg::rsp_type                  rsp_data,
   input  wire logic                              psel,
   input  wire logic                              penable,
   input  wire logic                              pwrite,
   input  wire logic [pts_pkg::CSR_ADDR_W-1:0]    paddr,
   input  wire logic [31:0]                       pwdata,
   output      logic [31:0]                       prdata,
   output      logic                              pready
);
   import pts_pkg::*;

   logic        table_present_ff;
   logic [15:0] task_count_ff;
   logic        cfg_write;
   logic        rsp_valid_ff, rsp_valid_in;
   rsp_type     rsp_data_ff;
   rsp_type     dp_rsp;
   logic        out_free;
   cmd_type     cmd;
   sts_type     sts;

   assign pready    = 1'b1;
   assign cfg_write = psel && penable && pwrite && pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         table_present_ff <= 1'b0;
         task_count_ff    <= 16'd0;
      end else if (cfg_write) begin
         unique case (paddr[2])
            REG_TABLE: table_present_ff <= pwdata[0];
            REG_COUNT: task_count_ff    <= pwdata[15:0];
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      unique case (paddr[2])
         REG_TABLE: prdata = {31'd0, table_present_ff};
         REG_COUNT: prdata = {16'd0, task_count_ff};
         default:   prdata = 32'd0;
      endcase
   end

   // output register
   assign out_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      if (cmd.emit) rsp_valid_in = 1'b1;
      else if (!rsp_stall) rsp_valid_in = 1'b0;
      else rsp_valid_in = rsp_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         rsp_data_ff <= dp_rsp;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   pts_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .out_free  (out_free),
      .sts       (sts),
      .cmd       (cmd)
   );

   pts_dpath u_dpath (
      .clock         (clock),
      .reset         (reset),
      .req_data      (req_data),
      .cfg_clear     (cfg_write),
      .table_present (table_present_ff),
      .task_count    (task_count_ff),
      .cmd           (cmd),
      .sts           (sts),
      .rsp_out       (dp_rsp)
   );

endmodule
`default_nettype wire
